>>> design/mfd_pkg.sv
// shared types and constants for the memory-sync frame decoder
`timescale 1ns / 1ps

package mfd_pkg;

  localparam int unsigned MEM_AW    = 16;
  localparam int unsigned BYTE_AW   = MEM_AW + 1;
  localparam int unsigned MEM_WORDS = 1 << MEM_AW;

  localparam logic [31:0] TRAILER_MAGIC = 32'hFF88_59EA;
  localparam logic [11:0] CODE_SYNC16   = 12'h0E0;
  localparam logic [11:0] CODE_SYNC32   = 12'h0E1;

  localparam logic [1:0] RESP_FRAME     = 2'd0;
  localparam logic [1:0] RESP_KEEPALIVE = 2'd1;
  localparam logic [1:0] RESP_READ      = 2'd2;

  typedef struct packed {
    logic        req_type;
    logic [7:0]  rx_byte;
    logic [15:0] read_addr;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  resp_kind;
    logic [11:0] msg_code;
    logic        trailer_ok;
    logic        addr_fault;
    logic [15:0] read_data;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_FRAME,
    CMD_KEEPALIVE
  } cmd_kind_t;

  // one unit of work for the back end
  typedef struct packed {
    cmd_kind_t          kind;
    logic [BYTE_AW-1:0] addr;
    logic [7:0]         data;
    logic [11:0]        msg_code;
    logic               trailer_ok;
    logic               addr_fault;
  } cmd_t;

  typedef enum logic {
    PHASE_HEADER,
    PHASE_BODY
  } phase_t;

endpackage

>>> design/mfd_front.sv
// front end: frame parser that turns stream bytes and read requests into commands
`timescale 1ns / 1ps

module mfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              take,
  input  mfd_pkg::in_item_t item,
  output logic              cmd_valid,
  output mfd_pkg::cmd_t     cmd
);

  mfd_pkg::phase_t               phase, phase_next;
  logic [31:0]                   header, header_next;
  logic [13:0]                   byte_index, byte_index_next;
  logic [mfd_pkg::BYTE_AW-1:0]   rec_addr, rec_addr_next;
  logic                          rec_addr_hi, rec_addr_hi_next;
  logic [15:0]                   rec_remaining, rec_remaining_next;
  logic [2:0]                    hdr_count, hdr_count_next;
  logic [31:0]                   trailer, trailer_next;
  logic                          abort, abort_next;

  logic [12:0] len;
  logic [13:0] padded;
  logic [11:0] code;
  logic        is_sync;
  logic        wide;
  logic [2:0]  abytes;
  logic [13:0] pos_inc;
  logic        rec_en;
  logic [31:0] header_acc;
  logic [31:0] trailer_shift;
  logic [7:0]  b;

  assign b             = item.rx_byte;
  assign len           = header[12:0];
  assign padded        = ({1'b0, len} + 14'd3) & ~14'd3;
  assign code          = header[31:20];
  assign is_sync       = (code == mfd_pkg::CODE_SYNC16) || (code == mfd_pkg::CODE_SYNC32);
  assign wide          = (code == mfd_pkg::CODE_SYNC32);
  assign abytes        = wide ? 3'd4 : 3'd2;
  assign pos_inc       = byte_index + 14'd1;
  assign rec_en        = (byte_index >= 14'd4) && (byte_index < {1'b0, len}) && !abort
                         && is_sync;
  assign header_acc    = header | ({24'b0, b} << {byte_index[1:0], 3'b000});
  assign trailer_shift = {b, trailer[31:8]};

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= mfd_pkg::PHASE_HEADER;
      header        <= '0;
      byte_index    <= '0;
      rec_addr      <= '0;
      rec_addr_hi   <= 1'b0;
      rec_remaining <= '0;
      hdr_count     <= '0;
      trailer       <= '0;
      abort         <= 1'b0;
    end else begin
      phase         <= phase_next;
      header        <= header_next;
      byte_index    <= byte_index_next;
      rec_addr      <= rec_addr_next;
      rec_addr_hi   <= rec_addr_hi_next;
      rec_remaining <= rec_remaining_next;
      hdr_count     <= hdr_count_next;
      trailer       <= trailer_next;
      abort         <= abort_next;
    end
  end

  always_comb begin
    phase_next         = phase;
    header_next        = header;
    byte_index_next    = byte_index;
    rec_addr_next      = rec_addr;
    rec_addr_hi_next   = rec_addr_hi;
    rec_remaining_next = rec_remaining;
    hdr_count_next     = hdr_count;
    trailer_next       = trailer;
    abort_next         = abort;
    cmd_valid          = 1'b0;
    cmd                = '0;

    if (take) begin
      if (item.req_type) begin
        cmd_valid = 1'b1;
        cmd.kind  = mfd_pkg::CMD_READ;
        cmd.addr  = {1'b0, item.read_addr};
      end else begin
        unique case (phase)
          mfd_pkg::PHASE_HEADER: begin
            header_next     = header_acc;
            byte_index_next = {12'b0, byte_index[1:0] + 2'd1};
            if (byte_index[1:0] == 2'd3) begin
              byte_index_next = '0;
              if (header_acc == 32'b0) begin
                cmd_valid = 1'b1;
                cmd.kind  = mfd_pkg::CMD_KEEPALIVE;
              end else begin
                phase_next = mfd_pkg::PHASE_BODY;
              end
            end
          end
          mfd_pkg::PHASE_BODY: begin
            if (rec_en) begin
              if (hdr_count == 3'd0 && rec_remaining != 16'd0) begin
                // record data byte becomes a write command for the memory
                cmd_valid          = 1'b1;
                cmd.kind           = mfd_pkg::CMD_WRITE;
                cmd.addr           = rec_addr;
                cmd.data           = b;
                rec_remaining_next = rec_remaining - 16'd1;
                rec_addr_next      = rec_addr + 1'b1;
              end else begin
                if (hdr_count < abytes) begin
                  unique case (hdr_count[1:0])
                    2'd0: begin
                      rec_addr_next    = {{(mfd_pkg::BYTE_AW-8){1'b0}}, b};
                      rec_addr_hi_next = 1'b0;
                    end
                    2'd1: rec_addr_next[15:8] = b;
                    2'd2: begin
                      rec_addr_next[16] = b[0];
                      rec_addr_hi_next  = rec_addr_hi | (b[7:1] != 7'd0);
                    end
                    2'd3: rec_addr_hi_next = rec_addr_hi | (b != 8'd0);
                  endcase
                end else if (hdr_count == abytes) begin
                  rec_remaining_next = rec_remaining | {8'b0, b};
                end else begin
                  rec_remaining_next = rec_remaining | {b, 8'b0};
                end
                if (hdr_count == abytes + 3'd1) begin
                  hdr_count_next = '0;
                  // wide address past the byte space aborts the rest of the sync
                  if (wide && pos_inc < {1'b0, len} && rec_addr_hi_next) begin
                    abort_next = 1'b1;
                  end
                end else begin
                  hdr_count_next = hdr_count + 3'd1;
                end
              end
            end

            if (byte_index >= padded) begin
              trailer_next = trailer_shift;
            end

            if (pos_inc >= padded + 14'd4) begin
              cmd_valid          = 1'b1;
              cmd.kind           = mfd_pkg::CMD_FRAME;
              cmd.msg_code       = code;
              cmd.trailer_ok     = (trailer_shift == mfd_pkg::TRAILER_MAGIC);
              cmd.addr_fault     = abort;
              phase_next         = mfd_pkg::PHASE_HEADER;
              header_next        = '0;
              byte_index_next    = '0;
              rec_addr_next      = '0;
              rec_addr_hi_next   = 1'b0;
              rec_remaining_next = '0;
              hdr_count_next     = '0;
              trailer_next       = '0;
              abort_next         = 1'b0;
            end else begin
              byte_index_next = pos_inc;
            end
          end
        endcase
      end
    end
  end

endmodule

>>> design/mfd_cmdq.sv
// short command queue between the parser and the memory side
`timescale 1ns / 1ps

module mfd_cmdq #(
  parameter int unsigned DEPTH = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  mfd_pkg::cmd_t push_data,
  output logic          has_room,
  output logic          head_valid,
  output mfd_pkg::cmd_t head_data,
  input  logic          pop
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  mfd_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;

  assign has_room   = (count < CNT_W'(DEPTH));
  assign head_valid = (count != '0);
  assign head_data  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/mfd_back.sv
// back end: byte-lane sync memory, clearing pass and result register
`timescale 1ns / 1ps

module mfd_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  mfd_pkg::cmd_t      head_data,
  output logic               pop,
  output logic               clearing,
  output logic               out_valid,
  input  logic               out_ready,
  output mfd_pkg::out_item_t out_data
);

  logic [7:0] mem_lo [mfd_pkg::MEM_WORDS];
  logic [7:0] mem_hi [mfd_pkg::MEM_WORDS];

  logic [mfd_pkg::MEM_AW-1:0] clr_idx;
  logic                       clr_active;
  logic [15:0]                rd_data;

  logic          s1_valid;
  mfd_pkg::cmd_t s1_cmd;
  logic          out_load;
  logic          s1_free;
  logic          head_is_write;
  logic          wr_en;
  logic          rd_en;
  mfd_pkg::out_item_t s1_result;

  assign clearing      = clr_active;
  assign out_load      = s1_valid && (!out_valid || out_ready);
  assign s1_free       = !s1_valid || out_load;
  assign head_is_write = (head_data.kind == mfd_pkg::CMD_WRITE);
  assign pop           = head_valid && !clr_active && (head_is_write || s1_free);
  assign wr_en         = pop && head_is_write;
  assign rd_en         = pop && (head_data.kind == mfd_pkg::CMD_READ);

  // zero fill after reset, one word a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_active <= 1'b1;
      clr_idx    <= '0;
    end else if (clr_active) begin
      clr_idx <= clr_idx + 1'b1;
      if (clr_idx == '1) begin
        clr_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (clr_active) begin
      mem_lo[clr_idx] <= 8'd0;
      mem_hi[clr_idx] <= 8'd0;
    end else if (wr_en) begin
      if (head_data.addr[0]) begin
        mem_hi[head_data.addr[mfd_pkg::BYTE_AW-1:1]] <= head_data.data;
      end else begin
        mem_lo[head_data.addr[mfd_pkg::BYTE_AW-1:1]] <= head_data.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= {mem_hi[head_data.addr[mfd_pkg::MEM_AW-1:0]],
                  mem_lo[head_data.addr[mfd_pkg::MEM_AW-1:0]]};
    end
  end

  always_comb begin
    s1_result = '0;
    unique case (s1_cmd.kind)
      mfd_pkg::CMD_READ: begin
        s1_result.resp_kind = mfd_pkg::RESP_READ;
        s1_result.read_data = rd_data;
      end
      mfd_pkg::CMD_FRAME: begin
        s1_result.resp_kind  = mfd_pkg::RESP_FRAME;
        s1_result.msg_code   = s1_cmd.msg_code;
        s1_result.trailer_ok = s1_cmd.trailer_ok;
        s1_result.addr_fault = s1_cmd.addr_fault;
      end
      mfd_pkg::CMD_KEEPALIVE: s1_result.resp_kind = mfd_pkg::RESP_KEEPALIVE;
      mfd_pkg::CMD_WRITE:     s1_result = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (pop && !head_is_write) begin
        s1_valid <= 1'b1;
      end else if (out_load) begin
        s1_valid <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && !head_is_write) begin
      s1_cmd <= head_data;
    end
    if (out_load) begin
      out_data <= s1_result;
    end
  end

endmodule

>>> design/memsync_frame_decoder.sv
// top level of the memory-sync frame decoder
`timescale 1ns / 1ps

// Input channel (in_valid/in_ready/in_data) carries either one stream byte
// (req_type 0) or a word read of the sync memory (req_type 1). Output channel
// (out_valid/out_ready/out_data) gives at most one result per input: a frame
// report at the last trailer byte, a keepalive report for an all-zero header,
// or the memory word of a read.
// Throughput is one input transfer per cycle while in_ready is high; every
// transfer causes at most one memory access, done by the single write/read
// port of the memory. An input transfer reaches its result through the
// command queue, the memory read register and the output register.
// Reads and writes go through one queue in order, so a read sees every byte
// written by the stream transfers before it.
// After reset the memory is zeroed by a pass over all 65536 words, one word a
// cycle; in_ready stays low throughout. When the receiver stalls, the result
// waits in the output register, the queue fills and in_ready drops only once
// all QUEUE_DEPTH entries are taken.
module memsync_frame_decoder #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  mfd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output mfd_pkg::out_item_t out_data
);

  logic          take;
  logic          cmd_valid;
  mfd_pkg::cmd_t cmd;
  logic          has_room;
  logic          head_valid;
  mfd_pkg::cmd_t head_data;
  logic          pop;
  logic          clearing;

  assign in_ready = has_room && !clearing;
  assign take     = in_valid && in_ready;

  mfd_front u_front (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .item      (in_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd)
  );

  mfd_cmdq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push       (cmd_valid),
    .push_data  (cmd),
    .has_room   (has_room),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop)
  );

  mfd_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_data  (head_data),
    .pop        (pop),
    .clearing   (clearing),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

endmodule
